FILE: hdl/wsac_pkg.sv
// ----------------------------------------------------------------------------
// wsac_pkg
// Shared types and constants for the worker slot admission controller:
// slot states, event kinds, error codes, beat payloads and cell commands.
// ----------------------------------------------------------------------------
package wsac_pkg;

  // default number of thread slots
  localparam int WSAC_SLOTS = 16;

  // reset value of the working limit
  localparam logic [4:0] WSAC_MAX_WORKING_RST = 5'd1;

  // per-slot state
  typedef enum logic [2:0] {
    ST_ABSENT   = 3'd0,
    ST_WAITING  = 3'd1,
    ST_WORKING  = 3'd2,
    ST_BLOCKING = 3'd3,
    ST_READY    = 3'd4
  } slot_state_t;

  // event kinds
  typedef enum logic [2:0] {
    KIND_JOIN        = 3'd0,
    KIND_LEAVE       = 3'd1,
    KIND_YIELD       = 3'd2,
    KIND_BEGIN_BLOCK = 3'd3,
    KIND_END_BLOCK   = 3'd4
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_MEMBER     = 2'd1,
    ERR_NOT_MEMBER = 2'd2,
    ERR_STATE      = 2'd3
  } err_t;

  // controller sequencer states
  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN
  } fsm_t;

  // input beat
  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] thread_slot;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic [2:0] caller_state;
    logic       wake_valid;
    logic [3:0] wake_slot;
    logic [1:0] error_code;
    logic [4:0] working_count;
  } out_item_t;

  // state write command toward the cell row
  typedef struct packed {
    logic        caller_we;
    slot_state_t caller_state;
    logic        wake_we;
  } cell_cmd_t;

endpackage

FILE: hdl/wsac_cell.sv
// ----------------------------------------------------------------------------
// wsac_cell
// One slot of the cell row: holds the slot state, takes direct writes and
// claims the scan token when waiting, otherwise hands it to the next cell.
// ----------------------------------------------------------------------------
module wsac_cell
  import wsac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   wr,
  input  logic        tok_in,
  output logic        tok_out,
  output slot_state_t state_o,
  output logic        claim_o
);

  slot_state_t st_r, st_nxt;
  logic        tok_r;

  // a waiting slot keeps the token and becomes working
  assign claim_o = tok_r && (st_r == ST_WAITING);
  assign tok_out = tok_r && !claim_o;
  assign state_o = st_r;

  // next slot state
  always_comb begin
    st_nxt = st_r;
    if (wr.caller_we) begin
      st_nxt = wr.caller_state;
    end else if (wr.wake_we || claim_o) begin
      st_nxt = ST_WORKING;
    end
  end

  // state and token registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_ABSENT;
      tok_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      tok_r <= tok_in;
    end
  end

endmodule

FILE: hdl/wsac_chain.sv
// ----------------------------------------------------------------------------
// wsac_chain
// Row of slot cells: decodes writes to single cells, threads the scan
// token from the lowest slot upward and reads back one slot state.
// ----------------------------------------------------------------------------
module wsac_chain
  import wsac_pkg::*;
#(
  parameter int  SLOTS = WSAC_SLOTS,
  localparam int IdxW  = $clog2(SLOTS)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cell_cmd_t       cmd,
  input  logic [IdxW-1:0] caller_idx,
  input  logic [IdxW-1:0] wake_idx,
  input  logic            scan_go,
  input  logic [IdxW-1:0] rd_idx,
  output slot_state_t     rd_state,
  output logic            claim_any
);

  cell_cmd_t   cell_wr [SLOTS];
  slot_state_t cell_st [SLOTS];
  logic [SLOTS:0]   tok;
  logic [SLOTS-1:0] claim;

  // token enters at the lowest slot
  assign tok[0] = scan_go;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    // per-cell write decode
    always_comb begin
      cell_wr[i].caller_we    = cmd.caller_we && (caller_idx == IdxW'(i));
      cell_wr[i].caller_state = cmd.caller_state;
      cell_wr[i].wake_we      = cmd.wake_we && (wake_idx == IdxW'(i));
    end

    wsac_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (cell_wr[i]),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1]),
      .state_o (cell_st[i]),
      .claim_o (claim[i])
    );
  end

  // read back one slot and flag a claim anywhere in the row
  assign rd_state  = cell_st[rd_idx];
  assign claim_any = |claim;

endmodule

FILE: hdl/worker_slot_admission_control_unit.sv
// ----------------------------------------------------------------------------
// worker_slot_admission_control_unit
// Admission controller limiting how many thread slots work at once, with
// a ready queue for slots coming back from blocking.
// ----------------------------------------------------------------------------
// Usage
//   Input: raise start with in_item (kind, thread_slot) while busy is low;
//   the beat is taken at that edge and busy rises until the result leaves.
//   Output: one result beat per event on out_item, marked by out_valid for
//   exactly one cycle; the receiver must take it, there is no stall.
//   Config: cfg_we with cfg_max_working writes the working limit; write
//   only while busy is low and no result is pending.
//   Timing: the accepted event runs in the EXEC state; the strobe is registered.
//   A leave or begin-blocking that frees capacity while the ready queue is
//   empty sends a token down the slot cell row, one cell per cycle, to find
//   the lowest waiting slot before the result strobe is given.
//   Events: start may be accepted in the cycle that carries the previous
//   result strobe, and not while busy is high; scans keep busy high longer.
//   Reset: all slots absent, ready queue empty, working count 0, limit 1.
//   The block takes events in the first cycle after reset.
// ----------------------------------------------------------------------------
module worker_slot_admission_control_unit
  import wsac_pkg::*;
#(
  parameter int SLOTS = WSAC_SLOTS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [4:0] cfg_max_working
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int CntW = $clog2(SLOTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(SLOTS);

  fsm_t            fsm_r, fsm_nxt;
  logic [2:0]      kind_r;
  logic [3:0]      slot_r;
  logic [4:0]      max_r;
  logic [4:0]      total_r, total_nxt;
  logic [IdxW-1:0] head_r, head_nxt;
  logic [IdxW-1:0] tail_r, tail_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [IdxW-1:0] scan_cnt_r, scan_cnt_nxt;
  slot_state_t     pend_r, pend_nxt;
  logic            out_valid_r, emit;
  out_item_t       out_item_r, res;
  logic [IdxW-1:0] fifo_mem_r [SLOTS];
  logic [IdxW-1:0] head_data_r;
  logic            push_we;

  cell_cmd_t       cmd;
  logic [IdxW-1:0] slot_idx;
  logic [IdxW-1:0] wake_idx;
  logic            scan_go;
  slot_state_t     rd_state;
  logic            claim_any;

  logic            in_range;
  slot_state_t     cur;
  err_t            err;
  logic [4:0]      total_dec;
  logic            cap_free;

  assign busy      = (fsm_r != FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign slot_idx  = IdxW'(slot_r);

  // cell row
  wsac_chain #(
    .SLOTS (SLOTS)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .caller_idx (slot_idx),
    .wake_idx   (wake_idx),
    .scan_go    (scan_go),
    .rd_idx     (slot_idx),
    .rd_state   (rd_state),
    .claim_any  (claim_any)
  );

  // event legality
  always_comb begin
    in_range = (32'(slot_r) < SLOTS);
    cur      = in_range ? rd_state : ST_ABSENT;
    if (!in_range) begin
      err = ERR_NOT_MEMBER;
    end else if (kind_r != KIND_JOIN && kind_r != KIND_LEAVE && kind_r != KIND_YIELD &&
                 kind_r != KIND_BEGIN_BLOCK && kind_r != KIND_END_BLOCK) begin
      err = ERR_STATE;
    end else if (kind_r == KIND_JOIN && cur != ST_ABSENT) begin
      err = ERR_MEMBER;
    end else if (kind_r != KIND_JOIN && cur == ST_ABSENT) begin
      err = ERR_NOT_MEMBER;
    end else if (kind_r == KIND_END_BLOCK && cur != ST_BLOCKING) begin
      err = ERR_STATE;
    end else if ((kind_r == KIND_LEAVE || kind_r == KIND_YIELD ||
                  kind_r == KIND_BEGIN_BLOCK) && cur != ST_WORKING) begin
      err = ERR_STATE;
    end else begin
      err = ERR_OK;
    end
    total_dec = total_r - 5'd1;
    cap_free  = (total_dec < max_r);
  end

  // sequencer: next state, cell commands, queue and result
  always_comb begin
    fsm_nxt          = fsm_r;
    total_nxt        = total_r;
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    cnt_nxt          = cnt_r;
    scan_cnt_nxt     = scan_cnt_r;
    pend_nxt         = pend_r;
    push_we          = 1'b0;
    scan_go          = 1'b0;
    emit             = 1'b0;
    wake_idx         = head_data_r;
    cmd.caller_we    = 1'b0;
    cmd.caller_state = ST_ABSENT;
    cmd.wake_we      = 1'b0;
    res.caller_state = cur;
    res.wake_valid   = 1'b0;
    res.wake_slot    = '0;
    res.error_code   = err;
    res.working_count = total_r;

    unique case (fsm_r)
      FSM_IDLE: begin
        if (start) begin
          fsm_nxt = FSM_EXEC;
        end
      end

      FSM_EXEC: begin
        fsm_nxt = FSM_IDLE;
        emit    = 1'b1;
        if (err == ERR_OK) begin
          case (kind_r)
            KIND_JOIN: begin
              cmd.caller_we = 1'b1;
              if (total_r < max_r) begin
                cmd.caller_state = ST_WORKING;
                total_nxt        = total_r + 5'd1;
              end else begin
                cmd.caller_state = ST_WAITING;
              end
            end

            KIND_LEAVE, KIND_BEGIN_BLOCK: begin
              cmd.caller_we    = 1'b1;
              cmd.caller_state = (kind_r == KIND_LEAVE) ? ST_ABSENT : ST_BLOCKING;
              total_nxt        = total_dec;
              if (cap_free && cnt_r != '0) begin
                // hand the freed place to the queue head
                cmd.wake_we    = 1'b1;
                head_nxt       = (head_r == LastIdx) ? '0 : head_r + 1'b1;
                cnt_nxt        = cnt_r - 1'b1;
                total_nxt      = total_r;
                res.wake_valid = 1'b1;
                res.wake_slot  = 4'(head_data_r);
              end else if (cap_free) begin
                // look for the lowest waiting slot
                scan_go      = 1'b1;
                scan_cnt_nxt = '0;
                pend_nxt     = cmd.caller_state;
                fsm_nxt      = FSM_SCAN;
                emit         = 1'b0;
              end
            end

            KIND_YIELD: begin
              if (cnt_r != '0) begin
                cmd.caller_we    = 1'b1;
                cmd.caller_state = ST_WAITING;
                cmd.wake_we      = 1'b1;
                head_nxt         = (head_r == LastIdx) ? '0 : head_r + 1'b1;
                cnt_nxt          = cnt_r - 1'b1;
                res.wake_valid   = 1'b1;
                res.wake_slot    = 4'(head_data_r);
              end
            end

            KIND_END_BLOCK: begin
              if (total_r < max_r) begin
                cmd.caller_we    = 1'b1;
                cmd.caller_state = ST_WORKING;
                total_nxt        = total_r + 5'd1;
              end else if (cnt_r < Depth) begin
                cmd.caller_we    = 1'b1;
                cmd.caller_state = ST_READY;
                push_we          = 1'b1;
                tail_nxt         = (tail_r == LastIdx) ? '0 : tail_r + 1'b1;
                cnt_nxt          = cnt_r + 1'b1;
              end
            end

            default: begin
            end
          endcase
          if (cmd.caller_we) begin
            res.caller_state = cmd.caller_state;
          end
          res.working_count = total_nxt;
        end
      end

      FSM_SCAN: begin
        res.caller_state  = pend_r;
        res.error_code    = ERR_OK;
        res.working_count = total_r;
        if (claim_any) begin
          total_nxt         = total_r + 5'd1;
          res.wake_valid    = 1'b1;
          res.wake_slot     = 4'(scan_cnt_r);
          res.working_count = total_r + 5'd1;
          emit              = 1'b1;
          fsm_nxt           = FSM_IDLE;
        end else if (scan_cnt_r == LastIdx) begin
          emit    = 1'b1;
          fsm_nxt = FSM_IDLE;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
        end
      end

      default: begin
        fsm_nxt = FSM_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= FSM_IDLE;
      max_r       <= WSAC_MAX_WORKING_RST;
      total_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r       <= fsm_nxt;
      total_r     <= total_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= emit;
      if (cfg_we) begin
        max_r <= cfg_max_working;
      end
    end
  end

  // input beat capture, scan bookkeeping and result payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= in_item.kind;
      slot_r <= in_item.thread_slot;
    end
    scan_cnt_r <= scan_cnt_nxt;
    pend_r     <= pend_nxt;
    if (emit) begin
      out_item_r <= res;
    end
  end

  // ready queue storage with registered head read
  always_ff @(posedge clk) begin
    if (push_we) begin
      fifo_mem_r[tail_r] <= slot_idx;
    end
    head_data_r <= fifo_mem_r[head_r];
  end

  // checks
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= Depth)
    else $error("ready queue count exceeds its depth");

  assert property (@(posedge clk) disable iff (!rst_n) out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  assert property (@(posedge clk) disable iff (!rst_n) claim_any |-> fsm_r == FSM_SCAN)
    else $error("cell claimed a slot outside a scan");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.error_code != ERR_OK) |-> !out_item_r.wake_valid)
    else $error("rejected event reports a wake");

  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> fsm_r == FSM_EXEC)
    else $error("accepted event did not enter execution");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the worker slot admission controller. Directed
// membership, blocking and ready-queue scenarios come first, then random
// event streams under several working limits. Every result beat is checked
// field by field against a cycle-free model of the slot states.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wsac_pkg::*;

  localparam int NSLOTS = WSAC_SLOTS;
  // settle time after the last result: pipeline plus a full cell scan
  localparam int DRAIN_CYCLES = NSLOTS + 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int EVENTS_PER_PHASE = 200;
  // event kinds the block has no meaning for
  localparam logic [2:0] KIND_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] KIND_RESERVED_LAST = 3'd7;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_item_t   in_item;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_we;
  logic [4:0] cfg_max_working;

  // admission model state
  slot_state_t slot_st [NSLOTS];
  logic [3:0]  ready_q [NSLOTS];
  logic [3:0]  rq_head;
  logic [3:0]  rq_tail;
  logic [4:0]  rq_count;
  logic [4:0]  working_now;
  logic [4:0]  limit_now;

  // results still owed by the block, oldest first
  out_item_t pending_results [$];

  int mismatches;
  int events_sent;
  int results_checked;
  int limit_writes;
  int wakes_seen;
  int outcome_seen [4];
  int burst_left;
  int cycle_count;

  worker_slot_admission_control_unit #(.SLOTS(NSLOTS)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_max_working (cfg_max_working)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // take the oldest slot off the ready queue
  function automatic logic [3:0] pop_ready();
    logic [3:0] s;
    s = ready_q[rq_head];
    rq_head = rq_head + 4'd1;
    rq_count = rq_count - 5'd1;
    return s;
  endfunction

  // hand freed capacity to the queue head, else the lowest waiting slot
  function automatic logic activate_next(output logic [3:0] who);
    logic found;
    who = '0;
    found = 1'b0;
    if (working_now < limit_now) begin
      if (rq_count != 0) begin
        who = pop_ready();
        found = 1'b1;
      end else begin
        for (int s = 0; s < NSLOTS; s++) begin
          if (!found && slot_st[s] == ST_WAITING) begin
            who = s[3:0];
            found = 1'b1;
          end
        end
      end
      if (found) begin
        slot_st[who] = ST_WORKING;
        working_now = working_now + 5'd1;
      end
    end
    return found;
  endfunction

  // apply one event to the model and return the result it should give
  function automatic out_item_t predict_admission(input in_item_t ev);
    out_item_t   r;
    slot_state_t cur;
    err_t        err;
    logic        woke;
    logic [3:0]  who;
    cur = slot_st[ev.thread_slot];
    woke = 1'b0;
    who = '0;
    if (ev.kind > KIND_END_BLOCK)
      err = ERR_STATE;
    else if (ev.kind == KIND_JOIN && cur != ST_ABSENT)
      err = ERR_MEMBER;
    else if (ev.kind != KIND_JOIN && cur == ST_ABSENT)
      err = ERR_NOT_MEMBER;
    else if (ev.kind == KIND_END_BLOCK && cur != ST_BLOCKING)
      err = ERR_STATE;
    else if (ev.kind != KIND_JOIN && ev.kind != KIND_END_BLOCK && cur != ST_WORKING)
      err = ERR_STATE;
    else
      err = ERR_OK;

    if (err == ERR_OK) begin
      case (ev.kind)
        KIND_JOIN: begin
          if (working_now < limit_now) begin
            slot_st[ev.thread_slot] = ST_WORKING;
            working_now = working_now + 5'd1;
          end else begin
            slot_st[ev.thread_slot] = ST_WAITING;
          end
        end
        KIND_LEAVE: begin
          slot_st[ev.thread_slot] = ST_ABSENT;
          working_now = working_now - 5'd1;
          woke = activate_next(who);
        end
        KIND_YIELD: begin
          // place goes to the queue head regardless of the limit
          if (rq_count != 0) begin
            who = pop_ready();
            slot_st[who] = ST_WORKING;
            slot_st[ev.thread_slot] = ST_WAITING;
            woke = 1'b1;
          end
        end
        KIND_BEGIN_BLOCK: begin
          slot_st[ev.thread_slot] = ST_BLOCKING;
          working_now = working_now - 5'd1;
          woke = activate_next(who);
        end
        default: begin
          // end blocking: back to work, or queue up as ready
          if (working_now < limit_now) begin
            slot_st[ev.thread_slot] = ST_WORKING;
            working_now = working_now + 5'd1;
          end else if (rq_count < NSLOTS) begin
            ready_q[rq_tail] = ev.thread_slot;
            rq_tail = rq_tail + 4'd1;
            rq_count = rq_count + 5'd1;
            slot_st[ev.thread_slot] = ST_READY;
          end
        end
      endcase
      cur = slot_st[ev.thread_slot];
    end

    r.caller_state = cur;
    r.wake_valid = woke;
    r.wake_slot = woke ? who : 4'd0;
    r.error_code = err;
    r.working_count = working_now;
    return r;
  endfunction

  // send one event beat, with random gaps between bursts
  task automatic send_event(input logic [2:0] kind, input logic [3:0] slot);
    in_item_t   ev;
    logic [6:0] noise;
    int         gap;
    ev.kind = kind;
    ev.thread_slot = slot;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        noise = 7'($urandom);
        @(negedge clk);
        start <= 1'b0;
        in_item <= noise;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= ev;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_admission(ev));
    events_sent++;
  endtask

  // stop sending and wait until the block has gone quiet
  task automatic drain_events();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // working limit is only written while the block is idle
  task automatic write_limit(input logic [4:0] value);
    drain_events();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_max_working <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_now = value;
    limit_writes++;
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat %h with no event pending", out_item));
      end else begin
        want = pending_results.pop_front();
        if (out_item.caller_state !== want.caller_state)
          report_mismatch($sformatf("beat %0d caller_state got %0d expected %0d",
                                    results_checked, out_item.caller_state,
                                    want.caller_state));
        if (out_item.wake_valid !== want.wake_valid)
          report_mismatch($sformatf("beat %0d wake_valid got %0d expected %0d",
                                    results_checked, out_item.wake_valid,
                                    want.wake_valid));
        if (out_item.wake_slot !== want.wake_slot)
          report_mismatch($sformatf("beat %0d wake_slot got %0d expected %0d",
                                    results_checked, out_item.wake_slot,
                                    want.wake_slot));
        if (out_item.error_code !== want.error_code)
          report_mismatch($sformatf("beat %0d error_code got %0d expected %0d",
                                    results_checked, out_item.error_code,
                                    want.error_code));
        if (out_item.working_count !== want.working_count)
          report_mismatch($sformatf("beat %0d working_count got %0d expected %0d",
                                    results_checked, out_item.working_count,
                                    want.working_count));
        outcome_seen[want.error_code]++;
        if (want.wake_valid) wakes_seen++;
        results_checked++;
      end
    end
  end

  // join, leave, idle yield, membership and state errors at limit 1
  task automatic test_membership();
    write_limit(5'd1);
    send_event(KIND_JOIN, 4'd0);
    send_event(KIND_JOIN, 4'd15);
    send_event(KIND_JOIN, 4'd0);
    send_event(KIND_LEAVE, 4'd3);
    send_event(KIND_YIELD, 4'd0);
    send_event(KIND_END_BLOCK, 4'd0);
    send_event(KIND_LEAVE, 4'd15);
  endtask

  // blocking, the ready queue and hand-over on yield
  task automatic test_blocking_queue();
    send_event(KIND_BEGIN_BLOCK, 4'd0);
    send_event(KIND_END_BLOCK, 4'd0);
    send_event(KIND_JOIN, 4'd7);
    send_event(KIND_YIELD, 4'd15);
    send_event(KIND_BEGIN_BLOCK, 4'd0);
    send_event(KIND_END_BLOCK, 4'd0);
    send_event(KIND_LEAVE, 4'd7);
  endtask

  // unknown kinds, then empty the pool again
  task automatic test_unknown_kinds();
    send_event(KIND_RESERVED_FIRST, 4'd0);
    send_event(KIND_RESERVED_FIRST + 3'd1, 4'd15);
    send_event(KIND_RESERVED_LAST, 4'd7);
    send_event(KIND_LEAVE, 4'd0);
    send_event(KIND_LEAVE, 4'd15);
  endtask

  // a zero limit admits nobody; raising it lets a leave wake the lowest waiter
  task automatic test_zero_limit();
    write_limit(5'd0);
    send_event(KIND_JOIN, 4'd3);
    send_event(KIND_JOIN, 4'd4);
    write_limit(5'd2);
    send_event(KIND_JOIN, 4'd5);
    send_event(KIND_LEAVE, 4'd5);
  endtask

  // mostly legal events picked from the current slot states, some noise
  task automatic test_random_traffic();
    logic [3:0] slot;
    logic [2:0] kind;
    logic [4:0] limit;
    int         roll;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       limit = 5'd16;
        1:       limit = 5'd1;
        2:       limit = 5'd31;
        default: limit = 5'($urandom_range(1, 16));
      endcase
      write_limit(limit);
      for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
        slot = 4'($urandom_range(0, NSLOTS - 1));
        // prefer slots that have a legal event to raise
        for (int t = 0; t < 6; t++)
          if (slot_st[slot] == ST_WAITING || slot_st[slot] == ST_READY)
            slot = 4'($urandom_range(0, NSLOTS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          kind = 3'($urandom_range(0, 7));
        end else begin
          case (slot_st[slot])
            ST_ABSENT:   kind = KIND_JOIN;
            ST_WORKING:  kind = (roll < 40) ? KIND_LEAVE :
                                (roll < 65) ? KIND_YIELD : KIND_BEGIN_BLOCK;
            ST_BLOCKING: kind = KIND_END_BLOCK;
            default:     kind = 3'($urandom_range(0, 7));
          endcase
        end
        send_event(kind, slot);
      end
    end
  endtask

  // sequence
  initial begin
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_max_working = WSAC_MAX_WORKING_RST;
    rst_n = 1'b0;
    for (int s = 0; s < NSLOTS; s++) begin
      slot_st[s] = ST_ABSENT;
      ready_q[s] = '0;
    end
    rq_head = '0;
    rq_tail = '0;
    rq_count = '0;
    working_now = '0;
    limit_now = WSAC_MAX_WORKING_RST;
    mismatches = 0;
    events_sent = 0;
    results_checked = 0;
    limit_writes = 0;
    wakes_seen = 0;
    outcome_seen = '{default: 0};
    burst_left = 0;
    cycle_count = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_membership();
    test_blocking_queue();
    test_unknown_kinds();
    test_zero_limit();
    test_random_traffic();

    drain_events();
    $display("covered %0d events, %0d result beats checked, %0d limit writes",
             events_sent, results_checked, limit_writes);
    $display("outcomes: ok %0d, member %0d, non-member %0d, bad state %0d, wakes %0d",
             outcome_seen[ERR_OK], outcome_seen[ERR_MEMBER],
             outcome_seen[ERR_NOT_MEMBER], outcome_seen[ERR_STATE], wakes_seen);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
